[hw/rtl/sit_pkg.sv]
// Shared types for the segment intersection test pipeline.
package sit_pkg;

  // Sign of one cross product: negative, zero, or (neither) positive.
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

  // Load enables for the two pipeline stages inside the cross product unit.
  typedef struct packed {
    logic prod;
    logic sign;
  } stage_en_t;

endpackage

[hw/rtl/segment_intersection_test_unit.sv]
// Top level of the segment intersection test: a four-stage crossing pipeline.
//
// Each request carries two line segments given by their end points as signed
// COORD_BITS-bit coordinates, and produces one result, crosses, which is 1
// exactly when the segments meet at a single point lying strictly inside both
// of them. Parallel, collinear and degenerate segments, and contacts at an end
// point, give 0. The test is exact: it takes the orientation of each segment's
// end points against the other segment's line, using full-width integer cross
// products, so no rounding is involved. When the output is not stalled, the
// block accepts one request every clock cycle, and the result of a request
// passes through the stage one, product, sign and output registers in turn.
// The four stages are: coordinate differences, the eight cross-product
// multiplications, the subtractions that give each orientation's sign, and
// the output register holding the combined answer. The multiply stage, at
// (COORD_BITS+1) by (COORD_BITS+1) bits, and the following wide subtraction
// set the clock rate. Each stage holds its request while the stage after it
// is full and stalled, so back-pressure from out_ready travels upstream
// without losing or repeating a request, and a new request is taken whenever
// any stage ahead has room.
module segment_intersection_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_first_start_x,
  input  logic signed [COORD_BITS-1:0] in_first_start_y,
  input  logic signed [COORD_BITS-1:0] in_first_end_x,
  input  logic signed [COORD_BITS-1:0] in_first_end_y,
  input  logic signed [COORD_BITS-1:0] in_second_start_x,
  input  logic signed [COORD_BITS-1:0] in_second_start_y,
  input  logic signed [COORD_BITS-1:0] in_second_end_x,
  input  logic signed [COORD_BITS-1:0] in_second_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_crosses
);

  localparam int DIFF_BITS = COORD_BITS + 1;

  // Sign-extended difference of two coordinates; never overflows.
  function automatic logic signed [DIFF_BITS-1:0] coord_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    coord_diff = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
  endfunction

  // Valid bit of each stage; stage four is the output register.
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_crosses_r, out_crosses_nxt;

  // A stage loads when it is empty or the stage after it loads this cycle.
  logic en1, en2, en3, en4;
  sit_pkg::stage_en_t cross_en;

  // Stage one: direction of each segment and offsets to the other segment's ends.
  logic signed [DIFF_BITS-1:0] d1x_r, d1y_r, d2x_r, d2y_r;
  logic signed [DIFF_BITS-1:0] e1x_r, e1y_r, f1x_r, f1y_r;
  logic signed [DIFF_BITS-1:0] g2x_r, g2y_r, h2x_r, h2y_r;

  // Orientation signs, registered at the end of stage three.
  sit_pkg::sign_t o1, o2, o3, o4;

  assign en4 = !out_valid_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign cross_en.prod = en2;
  assign cross_en.sign = en3;

  assign in_ready = en1;

  assign v1_nxt        = en1 ? in_valid : v1_r;
  assign v2_nxt        = en2 ? v1_r     : v2_r;
  assign v3_nxt        = en3 ? v2_r     : v3_r;
  assign out_valid_nxt = en4 ? v3_r     : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1x_r <= coord_diff(in_first_end_x,    in_first_start_x);
      d1y_r <= coord_diff(in_first_end_y,    in_first_start_y);
      d2x_r <= coord_diff(in_second_end_x,   in_second_start_x);
      d2y_r <= coord_diff(in_second_end_y,   in_second_start_y);
      e1x_r <= coord_diff(in_second_start_x, in_first_start_x);
      e1y_r <= coord_diff(in_second_start_y, in_first_start_y);
      f1x_r <= coord_diff(in_second_end_x,   in_first_start_x);
      f1y_r <= coord_diff(in_second_end_y,   in_first_start_y);
      g2x_r <= coord_diff(in_first_start_x,  in_second_start_x);
      g2y_r <= coord_diff(in_first_start_y,  in_second_start_y);
      h2x_r <= coord_diff(in_first_end_x,    in_second_start_x);
      h2y_r <= coord_diff(in_first_end_y,    in_second_start_y);
    end
  end

  // Stages two and three: second segment's ends against the first line, then
  // the first segment's ends against the second line.
  sit_cross #(.DIFF_BITS(DIFF_BITS)) u_cross_o1 (
    .clk(clk), .en(cross_en),
    .ux(d1x_r), .uy(d1y_r), .vx(e1x_r), .vy(e1y_r), .sign_o(o1)
  );

  sit_cross #(.DIFF_BITS(DIFF_BITS)) u_cross_o2 (
    .clk(clk), .en(cross_en),
    .ux(d1x_r), .uy(d1y_r), .vx(f1x_r), .vy(f1y_r), .sign_o(o2)
  );

  sit_cross #(.DIFF_BITS(DIFF_BITS)) u_cross_o3 (
    .clk(clk), .en(cross_en),
    .ux(d2x_r), .uy(d2y_r), .vx(g2x_r), .vy(g2y_r), .sign_o(o3)
  );

  sit_cross #(.DIFF_BITS(DIFF_BITS)) u_cross_o4 (
    .clk(clk), .en(cross_en),
    .ux(d2x_r), .uy(d2y_r), .vx(h2x_r), .vy(h2y_r), .sign_o(o4)
  );

  // Stage four: the segments cross when, for each segment, the other one's end
  // points lie strictly on opposite sides of its line. A zero sign covers the
  // collinear, degenerate and end point contact cases; parallel ones give equal signs.
  assign out_crosses_nxt = !o1.zero && !o2.zero && (o1.neg != o2.neg) &&
                           !o3.zero && !o4.zero && (o3.neg != o4.neg);

  always_ff @(posedge clk) begin
    if (en4) begin
      out_crosses_r <= out_crosses_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_crosses = out_crosses_r;

`ifndef SYNTHESIS
  // An accepted request always lands in stage one.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted request did not reach stage one");

  // A full stage one that cannot move on keeps its request and its d1x and h2y data.
  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !en2) |=> (v1_r && $stable(d1x_r) && $stable(h2y_r)))
    else $error("stage one lost or changed a stalled request");

  // A full stage two that cannot move on keeps its request.
  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en3) |=> v2_r)
    else $error("stage two lost a stalled request");

  // The input is refused only when every stage is full and the output stalls.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && out_valid_r && !out_ready))
    else $error("request refused while the pipeline had room");
`endif

endmodule

[hw/rtl/sit_cross.sv]
// Two-stage unit that returns the sign of ux*vy - uy*vx.
module sit_cross #(
  parameter int DIFF_BITS = 17
) (
  input  logic                        clk,
  input  sit_pkg::stage_en_t          en,
  input  logic signed [DIFF_BITS-1:0] ux,
  input  logic signed [DIFF_BITS-1:0] uy,
  input  logic signed [DIFF_BITS-1:0] vx,
  input  logic signed [DIFF_BITS-1:0] vy,
  output sit_pkg::sign_t              sign_o
);

  localparam int PROD_BITS = 2 * DIFF_BITS;

  logic signed [PROD_BITS-1:0] prod_a_r, prod_a_nxt;
  logic signed [PROD_BITS-1:0] prod_b_r, prod_b_nxt;
  logic signed [PROD_BITS:0]   cross_val;
  sit_pkg::sign_t              sign_r, sign_nxt;

  // Each product gets its own register before the subtraction.
  assign prod_a_nxt = PROD_BITS'(ux) * PROD_BITS'(vy);
  assign prod_b_nxt = PROD_BITS'(uy) * PROD_BITS'(vx);

  assign cross_val = $signed({prod_a_r[PROD_BITS-1], prod_a_r})
                   - $signed({prod_b_r[PROD_BITS-1], prod_b_r});

  always_comb begin
    sign_nxt.neg  = cross_val[PROD_BITS];
    sign_nxt.zero = (cross_val == '0);
  end

  always_ff @(posedge clk) begin
    if (en.prod) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
    end
    if (en.sign) begin
      sign_r <= sign_nxt;
    end
  end

  assign sign_o = sign_r;

endmodule
